>>> src/cgb_pkg.sv
// ----------------------------------------------------------------------------
// cgb_pkg: shared definitions for the glyph cell blitter
// Field widths, register indexes, opcodes and the font store request type.
// ----------------------------------------------------------------------------
package cgb_pkg;

	localparam int GLYPH_COUNT_DEF    = 256;
	localparam int ROWS_PER_GLYPH_DEF = 8;
	localparam int COORD_BITS         = 12;

	localparam int MAX_CELL = 8;
	localparam int ROW_W    = 3;
	localparam int POS_W    = 13;
	localparam int CLIP_W   = 13;
	localparam int CELL_W   = 4;
	localparam int CODE_W   = 8;
	localparam int ADDR_W   = 11;
	localparam int BYTE_W   = 8;
	localparam int PIX_W    = 12;
	localparam int COLOR_W  = 16;
	localparam int PEN_W    = 32;
	localparam int RANGE_W  = 16;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;
	localparam int IDX_W    = 3;

	// signed working width for the clip arithmetic
	localparam int CALC_W = (COORD_BITS + 2 > 15) ? COORD_BITS + 2 : 15;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	localparam logic [IDX_W-1:0] REG_CLIP_LEFT   = 3'd0;
	localparam logic [IDX_W-1:0] REG_CLIP_TOP    = 3'd1;
	localparam logic [IDX_W-1:0] REG_CLIP_RIGHT  = 3'd2;
	localparam logic [IDX_W-1:0] REG_CLIP_BOTTOM = 3'd3;
	localparam logic [IDX_W-1:0] REG_CELL_WIDTH  = 3'd4;
	localparam logic [IDX_W-1:0] REG_CELL_HEIGHT = 3'd5;
	localparam logic [IDX_W-1:0] REG_PEN_COLORS  = 3'd6;
	localparam logic [IDX_W-1:0] REG_CODE_RANGE  = 3'd7;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [BYTE_W-1:0] wr_data;
		logic [ADDR_W-1:0] rd_addr;
	} font_req_t;

endpackage

>>> src/cgb_cmd_if.sv
// ----------------------------------------------------------------------------
// cgb_cmd_if: command channel of the glyph cell blitter
// Valid/ready handshake carrying one load or draw item.
// ----------------------------------------------------------------------------
interface cgb_cmd_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic signed [cgb_pkg::POS_W-1:0]    pos_x;
	logic signed [cgb_pkg::POS_W-1:0]    pos_y;
	logic        [cgb_pkg::CODE_W-1:0]   char_code;
	logic        [cgb_pkg::ADDR_W-1:0]   font_addr;
	logic        [cgb_pkg::BYTE_W-1:0]   font_byte;

	modport source (output valid, op, pos_x, pos_y, char_code, font_addr, font_byte,
		input ready);
	modport sink (input valid, op, pos_x, pos_y, char_code, font_addr, font_byte,
		output ready);
endinterface

>>> src/cgb_pix_if.sv
// ----------------------------------------------------------------------------
// cgb_pix_if: pixel channel of the glyph cell blitter
// Valid/ready handshake carrying one RGB565 pixel item.
// ----------------------------------------------------------------------------
interface cgb_pix_if;
	logic                          valid;
	logic                          ready;
	logic [cgb_pkg::PIX_W-1:0]     pixel_x;
	logic [cgb_pkg::PIX_W-1:0]     pixel_y;
	logic [cgb_pkg::COLOR_W-1:0]   pixel_color;
	logic                          last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, last_pixel,
		output ready);
endinterface

>>> src/clipped_glyph_cell_blitter_top.sv
// ----------------------------------------------------------------------------
// clipped_glyph_cell_blitter_top: clipped 1-bpp glyph blit to RGB565 pixels
// Load item: writes one font byte, emits nothing.
// Draw item: a clip state (an empty cell ends there), then per visible row the font
//   fetch (FETCH, LOAD) and one pixel per cycle from the row shift register, unless pix stalls.
// First pixel leaves after the CLIP, FETCH, LOAD and EMIT states, from the output register.
// Reset clears control and loads register defaults; the font store is kept.
// ----------------------------------------------------------------------------
module clipped_glyph_cell_blitter_top #(
	parameter int GLYPH_COUNT    = cgb_pkg::GLYPH_COUNT_DEF,
	parameter int ROWS_PER_GLYPH = cgb_pkg::ROWS_PER_GLYPH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	cgb_cmd_if.sink                       cmd,
	cgb_pix_if.source                     pix,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cgb_pkg::PADDR_W-1:0]   paddr,
	input  logic [cgb_pkg::PDATA_W-1:0]   pwdata,
	output logic [cgb_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import cgb_pkg::*;

	localparam int DEPTH = GLYPH_COUNT * ROWS_PER_GLYPH;
	localparam int LIM_I = 1 << COORD_BITS;
	localparam logic signed [CALC_W-1:0] LIM = CALC_W'(LIM_I);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLIP  = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_LOAD  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	// configuration registers
	logic [CLIP_W-1:0]  clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
	logic [CELL_W-1:0]  cell_width_q, cell_height_q;
	logic [PEN_W-1:0]   pen_colors_q;
	logic [RANGE_W-1:0] code_range_q;

	// sequencer and cell datapath
	logic [2:0]               state_q;
	logic signed [POS_W-1:0]  pos_x_q, pos_y_q;
	logic [ADDR_W-1:0]        base_q;
	logic [CLIP_W-1:0]        x0_q, x_last_q, y_last_q, sx_q, sy_q;
	logic [ROW_W-1:0]         row_q, off_q;
	logic [BYTE_W-1:0]        shift_q;

	// output register
	logic                     pix_valid_q;
	logic [PIX_W-1:0]         pix_x_q, pix_y_q;
	logic [COLOR_W-1:0]       pix_color_q;
	logic                     pix_last_q;

	logic                     cfg_wr;
	logic [IDX_W-1:0]         cfg_idx;
	logic                     cmd_go, emit_go, x_end, y_end;
	logic [CODE_W-1:0]        first_code, last_code, glyph;
	font_req_t                font_req;
	logic [BYTE_W-1:0]        font_rd;

	logic signed [CALC_W-1:0] xs, ys, gwx, ghy, cl, ct, cr, cb;
	logic signed [CALC_W-1:0] x0, y0, x1, y1, xe, ye, x1m, y1m, xoff, yoff;
	logic                     cell_empty;
	logic [CELL_W-1:0]        gw, gh;

	// ------------------------------------------------------------------
	// APB register file: write on the access phase, read any time
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q   <= '0;
			clip_top_q    <= '0;
			clip_right_q  <= CLIP_W'(4096);
			clip_bottom_q <= CLIP_W'(4096);
			cell_width_q  <= CELL_W'(MAX_CELL);
			cell_height_q <= CELL_W'(MAX_CELL);
			pen_colors_q  <= PEN_W'(32'h0000_FFFF);
			code_range_q  <= RANGE_W'(16'hFF00);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_CLIP_LEFT:   clip_left_q   <= pwdata[CLIP_W-1:0];
				REG_CLIP_TOP:    clip_top_q    <= pwdata[CLIP_W-1:0];
				REG_CLIP_RIGHT:  clip_right_q  <= pwdata[CLIP_W-1:0];
				REG_CLIP_BOTTOM: clip_bottom_q <= pwdata[CLIP_W-1:0];
				REG_CELL_WIDTH:  cell_width_q  <= pwdata[CELL_W-1:0];
				REG_CELL_HEIGHT: cell_height_q <= pwdata[CELL_W-1:0];
				REG_PEN_COLORS:  pen_colors_q  <= pwdata[PEN_W-1:0];
				REG_CODE_RANGE:  code_range_q  <= pwdata[RANGE_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_CLIP_LEFT:   prdata = PDATA_W'(clip_left_q);
			REG_CLIP_TOP:    prdata = PDATA_W'(clip_top_q);
			REG_CLIP_RIGHT:  prdata = PDATA_W'(clip_right_q);
			REG_CLIP_BOTTOM: prdata = PDATA_W'(clip_bottom_q);
			REG_CELL_WIDTH:  prdata = PDATA_W'(cell_width_q);
			REG_CELL_HEIGHT: prdata = PDATA_W'(cell_height_q);
			REG_PEN_COLORS:  prdata = PDATA_W'(pen_colors_q);
			REG_CODE_RANGE:  prdata = PDATA_W'(code_range_q);
		endcase
	end

	// ------------------------------------------------------------------
	// Command side: take items only between cells
	// ------------------------------------------------------------------
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_go    = cmd.valid && cmd.ready;

	// codes outside first..last fall back to glyph 0
	assign first_code = code_range_q[CODE_W-1:0];
	assign last_code  = code_range_q[RANGE_W-1:CODE_W];
	assign glyph = (cmd.char_code < first_code || cmd.char_code > last_code) ?
		'0 : cmd.char_code - first_code;

	// load items write straight into the store; the read port follows the row
	assign font_req.wr_en   = cmd_go && (cmd.op == OP_LOAD);
	assign font_req.wr_addr = cmd.font_addr;
	assign font_req.wr_data = cmd.font_byte;
	assign font_req.rd_addr = base_q + ADDR_W'(row_q);

	cgb_font_mem #(
		.DEPTH (DEPTH)
	) u_font_mem (
		.clk     (clk),
		.req     (font_req),
		.rd_data (font_rd)
	);

	// ------------------------------------------------------------------
	// Clip: intersect the cell with the saturated clip rectangle
	// ------------------------------------------------------------------
	always_comb begin
		gw  = (cell_width_q  > CELL_W'(MAX_CELL)) ? CELL_W'(MAX_CELL) : cell_width_q;
		gh  = (cell_height_q > CELL_W'(MAX_CELL)) ? CELL_W'(MAX_CELL) : cell_height_q;
		xs  = $signed({{(CALC_W-POS_W){pos_x_q[POS_W-1]}}, pos_x_q});
		ys  = $signed({{(CALC_W-POS_W){pos_y_q[POS_W-1]}}, pos_y_q});
		gwx = $signed({{(CALC_W-CELL_W){1'b0}}, gw});
		ghy = $signed({{(CALC_W-CELL_W){1'b0}}, gh});
		cl  = $signed({{(CALC_W-CLIP_W){1'b0}}, clip_left_q});
		ct  = $signed({{(CALC_W-CLIP_W){1'b0}}, clip_top_q});
		cr  = $signed({{(CALC_W-CLIP_W){1'b0}}, clip_right_q});
		cb  = $signed({{(CALC_W-CLIP_W){1'b0}}, clip_bottom_q});
		if (cr > LIM) cr = LIM;
		if (cb > LIM) cb = LIM;
		xe  = xs + gwx;
		ye  = ys + ghy;
		x0  = (xs > cl) ? xs : cl;
		y0  = (ys > ct) ? ys : ct;
		x1  = (xe < cr) ? xe : cr;
		y1  = (ye < cb) ? ye : cb;
		cell_empty = (x1 <= x0) || (y1 <= y0);
		x1m  = x1 - CALC_W'(1);
		y1m  = y1 - CALC_W'(1);
		xoff = x0 - xs;
		yoff = y0 - ys;
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	assign x_end   = (sx_q == x_last_q);
	assign y_end   = (sy_q == y_last_q);
	assign emit_go = (state_q == ST_EMIT) && (!pix_valid_q || pix.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pix_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_go && cmd.op == OP_DRAW) state_q <= ST_CLIP;
				end
				ST_CLIP: begin
					state_q <= cell_empty ? ST_IDLE : ST_FETCH;
				end
				ST_FETCH: state_q <= ST_LOAD;
				ST_LOAD:  state_q <= ST_EMIT;
				ST_EMIT: begin
					// end of row: next row fetch, or done after the last row
					if (emit_go && x_end) state_q <= y_end ? ST_IDLE : ST_FETCH;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (emit_go) begin
				pix_valid_q <= 1'b1;
			end else if (pix.ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	// cell datapath: the row byte shifts out one pixel bit per emitted item
	always_ff @(posedge clk) begin
		if (cmd_go) begin
			pos_x_q <= cmd.pos_x;
			pos_y_q <= cmd.pos_y;
			base_q  <= ADDR_W'(int'(glyph) * ROWS_PER_GLYPH);
		end
		if (state_q == ST_CLIP) begin
			x0_q     <= x0[CLIP_W-1:0];
			sx_q     <= x0[CLIP_W-1:0];
			sy_q     <= y0[CLIP_W-1:0];
			x_last_q <= x1m[CLIP_W-1:0];
			y_last_q <= y1m[CLIP_W-1:0];
			off_q    <= xoff[ROW_W-1:0];
			row_q    <= yoff[ROW_W-1:0];
		end
		if (state_q == ST_LOAD) begin
			// drop the columns clipped on the left
			shift_q <= font_rd << off_q;
		end
		if (emit_go) begin
			pix_x_q     <= sx_q[PIX_W-1:0];
			pix_y_q     <= sy_q[PIX_W-1:0];
			pix_color_q <= shift_q[BYTE_W-1] ? pen_colors_q[COLOR_W-1:0] :
				pen_colors_q[PEN_W-1:COLOR_W];
			pix_last_q  <= x_end && y_end;
			shift_q     <= shift_q << 1;
			if (x_end) begin
				sx_q  <= x0_q;
				sy_q  <= sy_q + CLIP_W'(1);
				row_q <= row_q + ROW_W'(1);
			end else begin
				sx_q  <= sx_q + CLIP_W'(1);
			end
		end
	end

	assign pix.valid       = pix_valid_q;
	assign pix.pixel_x     = pix_x_q;
	assign pix.pixel_y     = pix_y_q;
	assign pix.pixel_color = pix_color_q;
	assign pix.last_pixel  = pix_last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_last_ends_cell: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go && x_end && y_end |=> state_q == ST_IDLE)
		else $error("last pixel did not end the cell");

	a_pix_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pix.valid) |-> $past(state_q) == ST_EMIT)
		else $error("pixel item raised outside the emit state");

	a_scan_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> sx_q <= x_last_q && sy_q <= y_last_q && sx_q >= x0_q)
		else $error("scan position left the clipped cell");

	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> $past(state_q) == ST_FETCH)
		else $error("font row loaded without a fetch cycle");

endmodule

>>> src/cgb_font_mem.sv
// ----------------------------------------------------------------------------
// cgb_font_mem: 1-bpp font store
// One write and one registered read per cycle; out-of-range reads give zero.
// ----------------------------------------------------------------------------
module cgb_font_mem #(
	parameter int DEPTH = cgb_pkg::GLYPH_COUNT_DEF * cgb_pkg::ROWS_PER_GLYPH_DEF
) (
	input  logic                        clk,
	input  cgb_pkg::font_req_t          req,
	output logic [cgb_pkg::BYTE_W-1:0]  rd_data
);
	import cgb_pkg::*;

	localparam int MI_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [ADDR_W:0] LIMIT = (ADDR_W + 1)'(DEPTH);

	logic [BYTE_W-1:0] store_q [DEPTH];
	logic [BYTE_W-1:0] rd_q;
	logic              rd_oob_q;
	logic              wr_ok;
	logic              rd_oob;

	assign wr_ok  = req.wr_en && ({1'b0, req.wr_addr} < LIMIT);
	assign rd_oob = ({1'b0, req.rd_addr} >= LIMIT);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			store_q[req.wr_addr[MI_W-1:0]] <= req.wr_data;
		end
		rd_q     <= store_q[req.rd_addr[MI_W-1:0]];
		rd_oob_q <= rd_oob;
	end

	// zero past the end of the store: those pixels take the background
	assign rd_data = rd_oob_q ? '0 : rd_q;

endmodule
